// File: hw/rtl/set_assoc_fifo_tag_store_assert.svh
// assertion macros shared by the tag store modules
`ifndef SET_ASSOC_FIFO_TAG_STORE_ASSERT_SVH
`define SET_ASSOC_FIFO_TAG_STORE_ASSERT_SVH

// implication checked every cycle outside reset
`define SAFTS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tag store check failed");

// next-cycle implication checked outside reset
`define SAFTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tag store check failed");

`endif

// File: hw/rtl/safts_pkg.sv
// package: types and constants of the tag store
`default_nettype none
package safts_pkg;
  localparam int unsigned SetBitsDefault = 6;
  localparam int unsigned WaysDefault = 4;
  localparam int unsigned AddrW = 32;
  localparam int unsigned MaxOffset = 12;
  localparam logic [3:0] OffsetReset = 4'd5;

  localparam logic [1:0] ModeLookup = 2'd0;
  localparam logic [1:0] ModeFill = 2'd1;
  localparam logic [1:0] ModeRemove = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        block_out_valid;
    logic [31:0] block_address_out;
  } out_item_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [3:0]  ob;
  } req_t;
endpackage
`default_nettype wire

// File: hw/rtl/safts_front.sv
// front end: accepts items, clamps offset, and queues requests
`default_nettype none
module safts_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire safts_pkg::in_item_t in_data,
  input  wire logic [3:0]       offset_bits,
  output logic                  req_valid,
  input  wire logic             req_pop,
  output safts_pkg::req_t       req
);
  `include "set_assoc_fifo_tag_store_assert.svh"

  // two-entry request queue
  safts_pkg::req_t q [2];
  logic [1:0] count;
  logic rd_ptr, wr_ptr;
  logic push, pop;
  safts_pkg::req_t enq;

  // clamp offset to its legal range
  always_comb begin
    enq.mode = in_data.mode;
    enq.address = in_data.address;
    enq.ob = (offset_bits > 4'(safts_pkg::MaxOffset)) ? 4'(safts_pkg::MaxOffset)
                                                      : offset_bits;
  end

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign req_valid = (count != 2'd0);
  assign pop = req_pop && req_valid;
  assign req = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= enq;
  end

  `SAFTS_ASSERT_IMP(a_no_overflow, clk, rst, count == 2'd2, !push)
  `SAFTS_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count != 2'd3)
  `SAFTS_ASSERT_NEXT(a_push_counts, clk, rst, push && !pop, count != 2'd0)
endmodule
`default_nettype wire

// File: hw/rtl/safts_back.sv
// back end: set read, way compare, tag and pointer update
`default_nettype none
module safts_back #(
  parameter int unsigned SET_BITS = safts_pkg::SetBitsDefault,
  parameter int unsigned WAYS = safts_pkg::WaysDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_pop,
  input  wire safts_pkg::req_t  req,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output safts_pkg::out_item_t  out_data
);
  `include "set_assoc_fifo_tag_store_assert.svh"

  localparam int unsigned Sets = 1 << SET_BITS;
  localparam int unsigned SetW = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TagW = 32;

  typedef enum logic [1:0] {
    S_READ = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  logic [TagW-1:0] tag_mem [Sets][WAYS];
  logic [WAYS-1:0] vbits [Sets];
  logic [WayW-1:0] fptr [Sets];

  logic [TagW-1:0] rd_tag [WAYS];
  logic [WAYS-1:0] rd_valid;
  logic [WayW-1:0] rd_ptr;
  safts_pkg::req_t cur;

  logic [SetW-1:0] set_idx, cur_set;
  logic [TagW-1:0] cur_tag;
  logic [TagW-1:0] req_shift;

  // split address into set and tag
  always_comb begin
    req_shift = req.address >> req.ob;
    set_idx = (SET_BITS > 0) ? SetW'(req_shift) & SetW'(Sets - 1) : '0;
    cur_tag = (cur.address >> cur.ob) >> SET_BITS;
    cur_set = (SET_BITS > 0) ? SetW'(cur.address >> cur.ob) & SetW'(Sets - 1) : '0;
  end

  // hit and free-way search over the set
  logic [WAYS-1:0] match;
  logic any_hit, any_free;
  logic [WayW-1:0] hit_way, free_way;
  always_comb begin
    any_hit = 1'b0;
    any_free = 1'b0;
    hit_way = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      match[w] = rd_valid[w] && (rd_tag[w] == cur_tag);
      if (match[w]) begin
        any_hit = 1'b1;
        hit_way = WayW'(w);
      end
      if (!rd_valid[w]) begin
        any_free = 1'b1;
        free_way = WayW'(w);
      end
    end
  end

  logic [WayW-1:0] ptr_next;
  assign ptr_next = (32'(rd_ptr) + 1 >= WAYS) ? '0 : WayW'(32'(rd_ptr) + 1);

  logic [63:0] evict_wide;
  logic [31:0] victim_addr, remove_addr;
  always_comb begin
    evict_wide = ((64'(rd_tag[rd_ptr]) << SET_BITS) | 64'(cur_set)) << cur.ob;
    victim_addr = evict_wide[31:0];
    remove_addr = (cur.address >> cur.ob) << cur.ob;
  end

  logic exec_go;
  assign exec_go = (state == S_EXEC) && (!out_valid || !out_stall);
  assign req_pop = (state == S_READ) && req_valid;

  // sequencer: read the set, then execute
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_READ;
      out_valid <= 1'b0;
    end else begin
      if (exec_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_READ: if (req_valid) state <= S_EXEC;
        S_EXEC: if (exec_go) state <= S_READ;
        default: state <= S_READ;
      endcase
    end
  end

  // set read and request capture
  always_ff @(posedge clk) begin
    if (req_pop) begin
      cur <= req;
      for (int w = 0; w < WAYS; w++) rd_tag[w] <= tag_mem[set_idx][w];
    end
  end

  // valid bits and pointers, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < Sets; s++) begin
        vbits[s] <= '0;
        fptr[s] <= '0;
      end
    end else if (exec_go) begin
      if (cur.mode == safts_pkg::ModeFill) begin
        if (any_free) vbits[cur_set][free_way] <= 1'b1;
        else fptr[cur_set] <= ptr_next;
      end else if (cur.mode == safts_pkg::ModeRemove && any_hit) begin
        vbits[cur_set][hit_way] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      rd_valid <= vbits[set_idx];
      rd_ptr <= fptr[set_idx];
    end
  end

  // tag write
  always_ff @(posedge clk) begin
    if (exec_go && cur.mode == safts_pkg::ModeFill)
      tag_mem[cur_set][any_free ? free_way : rd_ptr] <= cur_tag;
  end

  // result value for the current request
  safts_pkg::out_item_t out_data_next;
  always_comb begin
    out_data_next = '0;
    case (cur.mode)
      safts_pkg::ModeLookup: out_data_next.hit = any_hit;
      safts_pkg::ModeFill: if (!any_free) begin
        out_data_next.block_out_valid = 1'b1;
        out_data_next.block_address_out = victim_addr;
      end
      safts_pkg::ModeRemove: if (any_hit) begin
        out_data_next.hit = 1'b1;
        out_data_next.block_out_valid = 1'b1;
        out_data_next.block_address_out = remove_addr;
      end
      default: out_data_next = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (exec_go) out_data <= out_data_next;
  end

  `SAFTS_ASSERT_NEXT(a_pop_execs, clk, rst, req_pop, state == S_EXEC)
  `SAFTS_ASSERT_IMP(a_no_pop_exec, clk, rst, state == S_EXEC, !req_pop)
  `SAFTS_ASSERT_NEXT(a_go_output, clk, rst, exec_go, out_valid)
endmodule
`default_nettype wire

// File: hw/rtl/set_assoc_fifo_tag_store.sv
// Tag store of a set-associative cache with per-set FIFO replacement.
// Input channel in_valid/in_stall carries mode and address; output channel
// out_valid/out_stall returns hit, block_out_valid and block_address_out,
// one result per item, in order. Configuration channel cfg_valid/cfg_ready
// writes offset_bits (values above 12 act as 12); write it only when idle.
// A two-entry request queue parts the front end from the back end.
// The back end reads the set (tags, valid bits, pointer) in S_READ and, in
// S_EXEC, compares all ways, updates the set and registers the result; an
// accepted item passes the queue register and the S_READ capture registers
// before the result register raises out_valid.
// The read/update sequencer on the single set port takes a new item only in
// S_READ, so no item is taken before the previous result is registered.
// Reset (rst, synchronous) clears all valid bits and FIFO pointers at once
// and sets offset_bits to 5; tag contents stay undefined until written.
// While out_stall is high with out_valid set, the result holds, the back end
// waits, and the queue fills; in_stall rises once both queue entries are taken.
`default_nettype none
module set_assoc_fifo_tag_store #(
  parameter int unsigned SET_BITS = safts_pkg::SetBitsDefault,
  parameter int unsigned WAYS = safts_pkg::WaysDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire safts_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output safts_pkg::out_item_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [3:0]           cfg_data
);
  logic [3:0] offset_bits;
  logic req_valid, req_pop;
  safts_pkg::req_t req;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) offset_bits <= safts_pkg::OffsetReset;
    else if (cfg_valid && cfg_ready) offset_bits <= cfg_data;
  end

  safts_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .offset_bits,
    .req_valid, .req_pop, .req
  );

  safts_back #(.SET_BITS(SET_BITS), .WAYS(WAYS)) u_back (
    .clk, .rst, .req_valid, .req_pop, .req, .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire
